// File: rtl/assert_macros.svh
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge, switched off while reset is high.
`define ASSERT_CLKRST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lcdte_pkg.sv
package lcdte_pkg;

  // Request fields as they arrive on the input channel.
  typedef struct packed {
    logic [2:0] command;
    logic [5:0] col;
    logic [2:0] row;
    logic [7:0] char_code;
    logic [1:0] flag_select;
    logic       flag_value;
    logic       scroll_right;
  } req_t;

  // One bus nibble as it leaves on the output channel.
  typedef struct packed {
    logic [3:0] nibble;
    logic       register_select;
    logic [1:0] wait_class;
    logic       last;
  } nib_t;

  // One or two bytes queued between the decoder and the nibble serializer.
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    logic       rs0;
    logic [7:0] byte1;
    logic       rs1;
  } job_t;

  localparam logic [2:0] CMD_LOCATE = 3'd0;
  localparam logic [2:0] CMD_CHAR   = 3'd1;
  localparam logic [2:0] CMD_FLAGS  = 3'd2;
  localparam logic [2:0] CMD_CLEAR  = 3'd3;
  localparam logic [2:0] CMD_SCROLL = 3'd4;
  localparam logic [2:0] CMD_GLYPH  = 3'd5;

  localparam logic [1:0] FLAG_DISPLAY = 2'd0;
  localparam logic [1:0] FLAG_CURSOR  = 2'd1;
  localparam logic [1:0] FLAG_BLINK   = 2'd2;

  localparam logic [1:0] WAIT_NONE = 2'd0;
  localparam logic [1:0] WAIT_DATA = 2'd1;
  localparam logic [1:0] WAIT_CMD  = 2'd2;
  localparam logic [1:0] WAIT_SLOW = 2'd3;

  localparam logic [1:0] CFG_COLUMNS = 2'd0;
  localparam logic [1:0] CFG_ROWS    = 2'd1;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  localparam logic [7:0] INSN_SET_ADDR  = 8'h80;
  localparam logic [7:0] INSN_DISPLAY   = 8'h08;
  localparam logic [7:0] INSN_CLEAR     = 8'h01;
  localparam logic [7:0] INSN_SHIFT     = 8'h18;
  localparam logic [7:0] INSN_SHIFT_R   = 8'h04;
  localparam logic [7:0] INSN_SLOW_LIM  = 8'h04;

  localparam logic [2:0] MAX_ROWS = 3'd4;

  localparam logic [5:0] COLUMNS_RESET = 6'd16;
  localparam logic [2:0] ROWS_RESET    = 3'd2;
  localparam logic [2:0] FLAGS_RESET   = 3'b100;

  localparam logic [6:0] ROW_BASE [4] = '{7'h00, 7'h40, 7'h14, 7'h54};

  // Rows past the panel or past the supported maximum fold back to row 0.
  function automatic logic [1:0] fold_row(input logic [2:0] r, input logic [2:0] rows);
    logic [1:0] res;
    res = r[1:0];
    if ((r >= rows) || (r >= MAX_ROWS)) begin
      res = 2'd0;
    end
    return res;
  endfunction

  function automatic logic [7:0] addr_byte(input logic [5:0] c, input logic [1:0] r);
    logic [6:0] sum;
    sum = {1'b0, c} + ROW_BASE[r];
    return INSN_SET_ADDR | {1'b0, sum};
  endfunction

endpackage

// File: rtl/lcdte_fifo.sv
module lcdte_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lcdte_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output lcdte_pkg::job_t head
);
  import lcdte_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/lcdte_front.sv
module lcdte_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [5:0]      cfg_data,
  input  logic            fire,
  input  lcdte_pkg::req_t req,
  output logic            push,
  output lcdte_pkg::job_t job
);
  import lcdte_pkg::*;

  logic [5:0] columns;
  logic [2:0] rows;
  logic [5:0] cursor_col;
  logic [1:0] cursor_row;
  logic [2:0] display_flags;

  logic [5:0] cursor_col_next;
  logic [1:0] cursor_row_next;
  logic [2:0] display_flags_next;
  logic       has_out;

  logic       wrap;
  logic [1:0] wrap_row;
  logic [5:0] ch_col;
  logic [1:0] ch_row;
  logic [1:0] lf_row;
  logic [7:0] ch_byte;
  logic       ch_rs;
  logic [1:0] tgt_row;
  logic [2:0] flag_mask;

  // Decode of a character request: optional wrap to the next row, then
  // newline, carriage return or a plain data byte; also the folded target row and the flag mask.
  always_comb begin
    wrap     = (cursor_col >= columns);
    wrap_row = fold_row({1'b0, cursor_row} + 3'd1, rows);
    ch_col   = wrap ? 6'd0 : cursor_col;
    ch_row   = wrap ? wrap_row : cursor_row;
    lf_row   = fold_row({1'b0, ch_row} + 3'd1, rows);
    ch_byte  = req.char_code;
    ch_rs    = 1'b1;
    if (req.char_code == CHAR_LF) begin
      ch_byte = addr_byte(ch_col, lf_row);
      ch_rs   = 1'b0;
    end else if (req.char_code == CHAR_CR) begin
      ch_byte = addr_byte(6'd0, ch_row);
      ch_rs   = 1'b0;
    end
    tgt_row = fold_row(req.row, rows);
    case (req.flag_select)
      FLAG_DISPLAY: flag_mask = 3'b100;
      FLAG_CURSOR:  flag_mask = 3'b010;
      FLAG_BLINK:   flag_mask = 3'b001;
      default:      flag_mask = 3'b000;
    endcase
  end

  always_comb begin
    cursor_col_next    = cursor_col;
    cursor_row_next    = cursor_row;
    display_flags_next = display_flags;
    has_out            = 1'b0;
    job                = '0;
    case (req.command)
      CMD_LOCATE: begin
        has_out         = 1'b1;
        job.byte0       = addr_byte(req.col, tgt_row);
        cursor_col_next = req.col;
        cursor_row_next = tgt_row;
      end
      CMD_CHAR: begin
        has_out = 1'b1;
        if (wrap) begin
          job.two   = 1'b1;
          job.byte0 = addr_byte(6'd0, wrap_row);
          job.byte1 = ch_byte;
          job.rs1   = ch_rs;
        end else begin
          job.byte0 = ch_byte;
          job.rs0   = ch_rs;
        end
        if (req.char_code == CHAR_LF) begin
          cursor_col_next = ch_col;
          cursor_row_next = lf_row;
        end else if (req.char_code == CHAR_CR) begin
          cursor_col_next = 6'd0;
          cursor_row_next = ch_row;
        end else begin
          cursor_col_next = ch_col + 6'd1;
          cursor_row_next = ch_row;
        end
      end
      CMD_FLAGS: begin
        if (flag_mask != 3'b000) begin
          has_out            = 1'b1;
          display_flags_next = req.flag_value ? (display_flags | flag_mask)
                                              : (display_flags & ~flag_mask);
          job.byte0          = INSN_DISPLAY | {5'd0, display_flags_next};
        end
      end
      CMD_CLEAR: begin
        has_out         = 1'b1;
        job.byte0       = INSN_CLEAR;
        cursor_col_next = 6'd0;
        cursor_row_next = 2'd0;
      end
      CMD_SCROLL: begin
        has_out   = 1'b1;
        job.byte0 = req.scroll_right ? (INSN_SHIFT | INSN_SHIFT_R) : INSN_SHIFT;
      end
      CMD_GLYPH: begin
        has_out         = 1'b1;
        job.two         = 1'b1;
        job.byte0       = addr_byte(req.col, tgt_row);
        job.byte1       = req.char_code;
        job.rs1         = 1'b1;
        cursor_col_next = req.col;
        cursor_row_next = tgt_row;
      end
      default: begin
        has_out = 1'b0;
      end
    endcase
  end

  assign push = fire && has_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      columns       <= COLUMNS_RESET;
      rows          <= ROWS_RESET;
      cursor_col    <= '0;
      cursor_row    <= '0;
      display_flags <= FLAGS_RESET;
    end else begin
      if (cfg_we && (cfg_index == CFG_COLUMNS)) begin
        columns <= cfg_data;
      end
      if (cfg_we && (cfg_index == CFG_ROWS)) begin
        rows <= cfg_data[2:0];
      end
      if (fire) begin
        cursor_col    <= cursor_col_next;
        cursor_row    <= cursor_row_next;
        display_flags <= display_flags_next;
      end
    end
  end

endmodule

// File: rtl/lcdte_back.sv
module lcdte_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  lcdte_pkg::job_t job,
  output logic            pop,
  output logic            nib_valid,
  input  logic            nib_stall,
  output lcdte_pkg::nib_t nib
);
  import lcdte_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       job_end;
  logic [7:0] cur_byte;
  logic       cur_rs;
  nib_t       nib_next;

  assign load    = job_valid && (!nib_valid || !nib_stall);
  assign job_end = (idx == {job.two, 1'b1});
  assign pop     = load && job_end;

  always_comb begin
    cur_byte = idx[1] ? job.byte1 : job.byte0;
    cur_rs   = idx[1] ? job.rs1 : job.rs0;
    nib_next.nibble          = idx[0] ? cur_byte[3:0] : cur_byte[7:4];
    nib_next.register_select = cur_rs;
    nib_next.last            = job_end;
    if (!idx[0]) begin
      nib_next.wait_class = WAIT_NONE;
    end else if (cur_rs) begin
      nib_next.wait_class = WAIT_DATA;
    end else if (cur_byte < INSN_SLOW_LIM) begin
      nib_next.wait_class = WAIT_SLOW;
    end else begin
      nib_next.wait_class = WAIT_CMD;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nib <= nib_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      nib_valid <= 1'b0;
    end else begin
      if (load) begin
        nib_valid <= 1'b1;
        idx       <= job_end ? 2'd0 : idx + 2'd1;
      end else if (!nib_stall) begin
        nib_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/char_lcd_text_command_engine_top.sv
// Channel   | Handshake             | Payload
// ----------+-----------------------+------------------------------------------
// req       | req_valid / req_stall | lcdte_pkg::req_t, one request
// nib       | nib_valid / nib_stall | lcdte_pkg::nib_t, one bus nibble
// cfg       | cfg_valid / cfg_ready | cfg_index selects columns or rows
//
// A request is decoded in the cycle it is accepted and its bytes enter the
// job queue at that same edge; the serializer then sends one nibble per
// cycle while nib_stall is low and the queue holds a job, and a request
// turns into 0, 2 or 4 nibbles on the output side.
// With the queue empty, a job is written into the queue at acceptance and
// then loads the output register, from which its first nibble is offered.
// Reset (rst, synchronous) empties the queue, drops nib_valid, homes the
// cursor and restores 16 columns, 2 rows and the display-on flag.
// req_stall rises only while the job queue is full; nib_stall holds the
// output register and, once the queue fills, backs up into req_stall.
module char_lcd_text_command_engine_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  lcdte_pkg::req_t req,
  output logic            nib_valid,
  input  logic            nib_stall,
  output lcdte_pkg::nib_t nib,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [5:0]      cfg_data
);
  import lcdte_pkg::*;

  logic req_fire;
  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  logic pop;
  job_t head;

  // Register writes are taken in any cycle; the front end applies them
  // directly to its configuration registers.
  assign cfg_ready = 1'b1;

  // The queue absorbs a request whenever there is room, independent of
  // whether the serializer is currently stalled downstream.
  assign req_stall = q_full;
  assign req_fire  = req_valid && !req_stall;

  // Front end: request decode, cursor and display-flag tracking.
  lcdte_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (req_fire),
    .req       (req),
    .push      (push),
    .job       (push_job)
  );

  // Job queue between decode and serialization.
  lcdte_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  // Back end: splits each queued byte into high and low nibble.
  lcdte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job       (head),
    .pop       (pop),
    .nib_valid (nib_valid),
    .nib_stall (nib_stall),
    .nib       (nib)
  );

endmodule

// File: rtl/lcdte_checker.sv
`include "assert_macros.svh"

module lcdte_checker (
  input logic            clk,
  input logic            rst,
  input logic            nib_valid,
  input logic            nib_stall,
  input lcdte_pkg::nib_t nib
);
  import lcdte_pkg::*;

  // A stalled nibble stays offered and unchanged.
  `ASSERT_CLKRST(a_nib_hold, clk, rst, nib_valid && nib_stall |=> nib_valid && $stable(nib), "stalled nibble changed")

  // The first nibble of a byte never closes a transaction.
  `ASSERT_CLKRST(a_first_not_last, clk, rst, nib_valid && (nib.wait_class == WAIT_NONE) |-> !nib.last, "last on high nibble")

  // Data nibbles only carry the data wait or none.
  `ASSERT_CLKRST(a_data_wait, clk, rst, nib_valid && nib.register_select |-> (nib.wait_class == WAIT_NONE) || (nib.wait_class == WAIT_DATA), "bad wait on data nibble")

  // Instruction nibbles never carry the data wait.
  `ASSERT_CLKRST(a_insn_wait, clk, rst, nib_valid && !nib.register_select |-> nib.wait_class != WAIT_DATA, "data wait on instruction nibble")

  // Nothing is offered in the cycle after a reset edge.
  `ASSERT_CLK(a_reset_quiet, clk, rst |=> !nib_valid, "nibble offered right after reset")

endmodule

bind char_lcd_text_command_engine_top lcdte_checker u_lcdte_checker (.*);

// File: verif/char_lcd_text_command_engine_top_tb.sv
module char_lcd_text_command_engine_top_tb;
  import lcdte_pkg::*;

  // Command and flag codes that the block must ignore without any bus traffic.
  localparam logic [2:0] CMD_RESERVED_LO = 3'd6;
  localparam logic [2:0] CMD_RESERVED_HI = 3'd7;
  localparam logic [1:0] FLAG_RESERVED   = 2'd3;

  // Register-select values carried with every nibble.
  localparam logic RS_INSN = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // Cycles to let pass once nothing is expected. This covers the output
  // register, a full job queue and any request that made no nibbles.
  localparam int SETTLE_CYCLES = 12;

  // The watchdog limit lies far above the length of a clean run.
  localparam int CYCLE_LIMIT = 300000;

  // Length of the long receiver hold-off that backs the block up into req_stall.
  localparam int LONG_HOLD_CYCLES = 150;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_pattern_e;

  // The scoreboard keeps its own copy of the cursor, the display flags and the
  // panel geometry. Each accepted request is expanded here into the nibble
  // train the block should send, and each nibble leaving the block is
  // compared with the oldest nibble still owed.
  class lcd_nibble_scoreboard;
    logic [5:0] columns;
    logic [2:0] rows;
    logic [5:0] cursor_col;
    logic [1:0] cursor_row;
    logic [2:0] display_flags;
    nib_t       owed_nibbles[$];
    nib_t       train[$];
    int         mismatches;
    int         checked;

    function new();
      columns       = COLUMNS_RESET;
      rows          = ROWS_RESET;
      cursor_col    = '0;
      cursor_row    = '0;
      display_flags = FLAGS_RESET;
      mismatches    = 0;
      checked       = 0;
    endfunction

    function void configure(input logic [1:0] index, input logic [5:0] value);
      if (index == CFG_COLUMNS) begin
        columns = value;
      end else if (index == CFG_ROWS) begin
        rows = value[2:0];
      end
    endfunction

    // A byte goes out high nibble first; only the low nibble carries a wait.
    function void add_byte(input logic [7:0] b, input logic rs);
      nib_t hi;
      nib_t lo;
      hi.nibble          = b[7:4];
      hi.register_select = rs;
      hi.wait_class      = WAIT_NONE;
      hi.last            = 1'b0;
      lo.nibble          = b[3:0];
      lo.register_select = rs;
      lo.last            = 1'b0;
      if (rs == RS_DATA) begin
        lo.wait_class = WAIT_DATA;
      end else if (b < INSN_SLOW_LIM) begin
        lo.wait_class = WAIT_SLOW;
      end else begin
        lo.wait_class = WAIT_CMD;
      end
      train.push_back(hi);
      train.push_back(lo);
    endfunction

    // Moves the cursor and sends the address byte. A row past the panel or
    // past the fourth line folds back to the top line.
    function void move_to(input logic [5:0] c, input logic [2:0] r);
      logic [6:0] offset;
      if ((r >= rows) || (r >= MAX_ROWS)) begin
        r = 3'd0;
      end
      cursor_col = c;
      cursor_row = r[1:0];
      offset     = {1'b0, c} + ROW_BASE[r[1:0]];
      add_byte(INSN_SET_ADDR | {1'b0, offset}, RS_INSN);
    endfunction

    function int note_request(input req_t r);
      logic [2:0] mask;
      nib_t       tail;
      train.delete();
      case (r.command)
        CMD_LOCATE: begin
          move_to(r.col, r.row);
        end
        CMD_CHAR: begin
          // A cursor sitting at or past the right edge wraps before anything else.
          if (cursor_col >= columns) begin
            move_to(6'd0, {1'b0, cursor_row} + 3'd1);
          end
          if (r.char_code == CHAR_LF) begin
            move_to(cursor_col, {1'b0, cursor_row} + 3'd1);
          end else if (r.char_code == CHAR_CR) begin
            move_to(6'd0, {1'b0, cursor_row});
          end else begin
            add_byte(r.char_code, RS_DATA);
            cursor_col = cursor_col + 6'd1;
          end
        end
        CMD_FLAGS: begin
          case (r.flag_select)
            FLAG_DISPLAY: mask = 3'b100;
            FLAG_CURSOR:  mask = 3'b010;
            FLAG_BLINK:   mask = 3'b001;
            default:      mask = 3'b000;
          endcase
          if (mask != 3'b000) begin
            if (r.flag_value) begin
              display_flags = display_flags | mask;
            end else begin
              display_flags = display_flags & ~mask;
            end
            add_byte(INSN_DISPLAY | {5'b00000, display_flags}, RS_INSN);
          end
        end
        CMD_CLEAR: begin
          add_byte(INSN_CLEAR, RS_INSN);
          cursor_col = '0;
          cursor_row = '0;
        end
        CMD_SCROLL: begin
          add_byte(r.scroll_right ? (INSN_SHIFT | INSN_SHIFT_R) : INSN_SHIFT, RS_INSN);
        end
        CMD_GLYPH: begin
          move_to(r.col, r.row);
          add_byte(r.char_code, RS_DATA);
        end
        default: begin
        end
      endcase
      if (train.size() > 0) begin
        tail      = train.pop_back();
        tail.last = 1'b1;
        train.push_back(tail);
      end
      foreach (train[i]) begin
        owed_nibbles.push_back(train[i]);
      end
      return train.size();
    endfunction

    function void note_failure(input string text);
      mismatches++;
      if (mismatches <= 10) begin
        $display("tb: mismatch: %s", text);
      end
    endfunction

    function void check_nibble(input nib_t got);
      nib_t want;
      if (owed_nibbles.size() == 0) begin
        note_failure($sformatf("unexpected nibble %h rs %b wait %0d last %b",
                               got.nibble, got.register_select, got.wait_class, got.last));
        return;
      end
      want = owed_nibbles.pop_front();
      checked++;
      if ((got.nibble !== want.nibble) || (got.register_select !== want.register_select) ||
          (got.wait_class !== want.wait_class) || (got.last !== want.last)) begin
        note_failure($sformatf(
          "nibble %0d: expected %h rs %b wait %0d last %b, got %h rs %b wait %0d last %b",
          checked, want.nibble, want.register_select, want.wait_class, want.last,
          got.nibble, got.register_select, got.wait_class, got.last));
      end
    endfunction

    function int pending();
      return owed_nibbles.size();
    endfunction

    function void flush_owed();
      nib_t want;
      while (owed_nibbles.size() > 0) begin
        want = owed_nibbles.pop_front();
        note_failure($sformatf("nibble %h rs %b wait %0d last %b never arrived",
                               want.nibble, want.register_select, want.wait_class, want.last));
      end
    endfunction
  endclass

  // Every block input starts at a known value.
  logic clk         = 1'b0;
  logic rst         = 1'b1;
  logic req_valid   = 1'b0;
  req_t req         = '0;
  logic nib_stall   = 1'b0;
  logic cfg_valid   = 1'b0;
  logic [1:0] cfg_index = CFG_COLUMNS;
  logic [5:0] cfg_data  = '0;

  logic req_stall;
  logic nib_valid;
  nib_t nib;
  logic cfg_ready;

  lcd_nibble_scoreboard sb;

  // Sender bookkeeping. The sender works in bursts; straight_run forces a run
  // of back-to-back requests while the receiver is holding off.
  bit offering      = 1'b0;
  int burst_left    = 0;
  int straight_run  = 0;
  int total_requests = 0;
  int quiet_requests = 0;
  int geometries    = 0;

  // Receiver bookkeeping. The main sequence asks for a long hold-off by
  // bumping holds_asked; the receiver notices and counts the hold itself.
  int holds_asked = 0;
  int holds_done  = 0;
  int hold_left   = 0;
  int seg_left    = 0;
  stall_pattern_e stall_pattern = STALL_NONE;

  int cycle_count = 0;

  char_lcd_text_command_engine_top DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .nib_valid (nib_valid),
    .nib_stall (nib_stall),
    .nib       (nib),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // Output stall pattern. Segments of random length pick one of four patterns,
  // so stalls land on every nibble position, and some stretches have none.
  always @(posedge clk) begin
    if (holds_asked != holds_done) begin
      holds_done = holds_asked;
      hold_left  = LONG_HOLD_CYCLES;
    end
    if (seg_left == 0) begin
      stall_pattern = stall_pattern_e'($urandom_range(0, 3));
      seg_left      = $urandom_range(5, 60);
    end else begin
      seg_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      nib_stall <= 1'b1;
    end else begin
      case (stall_pattern)
        STALL_NONE:  nib_stall <= 1'b0;
        STALL_LIGHT: nib_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: nib_stall <= ($urandom_range(0, 9) < 7);
        default:     nib_stall <= ~nib_stall;
      endcase
    end
  end

  // Every nibble transaction on the output side is checked as it is accepted.
  always @(posedge clk) begin
    if ((rst === 1'b0) && (nib_valid === 1'b1) && (nib_stall === 1'b0)) begin
      sb.check_nibble(nib);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  function automatic req_t make_req(input logic [2:0] command, input logic [5:0] col,
                                    input logic [2:0] row, input logic [7:0] char_code,
                                    input logic [1:0] flag_select, input logic flag_value,
                                    input logic scroll_right);
    req_t r;
    r.command      = command;
    r.col          = col;
    r.row          = row;
    r.char_code    = char_code;
    r.flag_select  = flag_select;
    r.flag_value   = flag_value;
    r.scroll_right = scroll_right;
    return r;
  endfunction

  // Position for locate and glyph requests: mostly on the panel, including the
  // column just past the right edge, and now and then anywhere the field allows.
  function automatic void aim(inout req_t r, input logic [5:0] cols, input logic [2:0] rws);
    if ($urandom_range(0, 6) != 0) begin
      r.col = 6'($urandom_range(0, cols));
    end
    if ($urandom_range(0, 6) != 0) begin
      r.row = 3'($urandom_range(0, rws - 1));
    end
  endfunction

  // Random requests are half text with line control, the rest commands and
  // a few percent of raw noise, which also reaches the unused codes.
  function automatic req_t random_request(input logic [5:0] cols, input logic [2:0] rws);
    req_t        r;
    logic [31:0] raw;
    int          pick;
    int          sub;
    raw  = $urandom;
    r    = raw[$bits(req_t)-1:0];
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      r.command = CMD_CHAR;
      sub = $urandom_range(0, 19);
      if (sub == 0) begin
        r.char_code = CHAR_LF;
      end else if (sub == 1) begin
        r.char_code = CHAR_CR;
      end else if (sub > 3) begin
        r.char_code = 8'($urandom_range(8'h20, 8'h7E));
      end
    end else if (pick < 62) begin
      r.command = CMD_LOCATE;
      aim(r, cols, rws);
    end else if (pick < 70) begin
      r.command = CMD_GLYPH;
      aim(r, cols, rws);
      if ($urandom_range(0, 3) != 0) begin
        r.char_code = 8'($urandom_range(0, 7));
      end
    end else if (pick < 78) begin
      r.command = CMD_FLAGS;
      r.flag_select = ($urandom_range(0, 19) == 0) ? FLAG_RESERVED : 2'($urandom_range(0, 2));
    end else if (pick < 84) begin
      r.command = CMD_CLEAR;
    end else if (pick < 92) begin
      r.command = CMD_SCROLL;
    end else if (pick < 95) begin
      r.command = ($urandom_range(0, 1) == 0) ? CMD_RESERVED_LO : CMD_RESERVED_HI;
    end
    return r;
  endfunction

  task automatic drop_req();
    if (offering) begin
      req_valid <= 1'b0;
      offering  = 1'b0;
    end
  endtask

  // Offers one request and waits for its transaction. The payload holds still
  // while stalled. After acceptance the sender either keeps valid high for the
  // next request or closes the burst with a random gap.
  task automatic offer(input req_t r, output bit made_traffic);
    req       <= r;
    req_valid <= 1'b1;
    offering  = 1'b1;
    do begin
      @(posedge clk);
    end while (req_stall !== 1'b0);
    total_requests++;
    made_traffic = (sb.note_request(r) != 0);
    if (!made_traffic) begin
      quiet_requests++;
    end
    if (straight_run > 0) begin
      straight_run--;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      drop_req();
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
    end
  endtask

  // Stops offering, waits until every owed nibble has come, then lets the
  // block's pipeline run dry.
  task automatic settle();
    drop_req();
    while (sb.pending() > 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both geometry registers go out as back-to-back transactions on the
  // configuration channel; the scoreboard follows each write as it lands.
  task automatic write_geometry(input logic [5:0] cols, input logic [2:0] rws);
    cfg_index <= CFG_COLUMNS;
    cfg_data  <= cols;
    cfg_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    sb.configure(CFG_COLUMNS, cols);
    cfg_index <= CFG_ROWS;
    cfg_data  <= {3'b000, rws};
    do begin
      @(posedge clk);
    end while (cfg_ready !== 1'b1);
    sb.configure(CFG_ROWS, {3'b000, rws});
    cfg_valid <= 1'b0;
    geometries++;
  endtask

  // Directed requests under the reset geometry of 16 columns and 2 rows: field
  // extremes, every command, column wrap ahead of text, newline and carriage
  // return, a row that folds to the top line, slow clear and the unused codes.
  task automatic run_directed();
    req_t script[$];
    bit   made_traffic;
    script.push_back(make_req(CMD_LOCATE, 6'd0, 3'd0, 8'h00, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_LOCATE, 6'd63, 3'd7, 8'hFF, FLAG_RESERVED, 1'b1, 1'b1));
    script.push_back(make_req(CMD_LOCATE, 6'd15, 3'd1, 8'h00, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_CHAR, 6'd0, 3'd0, 8'h41, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_CHAR, 6'd63, 3'd7, 8'hFF, FLAG_RESERVED, 1'b1, 1'b1));
    script.push_back(make_req(CMD_CHAR, 6'd0, 3'd0, 8'h00, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_CHAR, 6'd0, 3'd0, CHAR_LF, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_CHAR, 6'd0, 3'd0, CHAR_CR, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_LOCATE, 6'd16, 3'd1, 8'h00, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_CHAR, 6'd0, 3'd0, CHAR_LF, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_LOCATE, 6'd16, 3'd0, 8'h00, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_CHAR, 6'd0, 3'd0, CHAR_CR, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_FLAGS, 6'd0, 3'd0, 8'h00, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_FLAGS, 6'd0, 3'd0, 8'h00, FLAG_CURSOR, 1'b1, 1'b0));
    script.push_back(make_req(CMD_FLAGS, 6'd0, 3'd0, 8'h00, FLAG_BLINK, 1'b1, 1'b0));
    script.push_back(make_req(CMD_FLAGS, 6'd0, 3'd0, 8'h00, FLAG_RESERVED, 1'b1, 1'b0));
    script.push_back(make_req(CMD_FLAGS, 6'd0, 3'd0, 8'h00, FLAG_DISPLAY, 1'b1, 1'b0));
    script.push_back(make_req(CMD_FLAGS, 6'd0, 3'd0, 8'h00, FLAG_CURSOR, 1'b0, 1'b0));
    script.push_back(make_req(CMD_CLEAR, 6'd63, 3'd7, 8'hFF, FLAG_RESERVED, 1'b1, 1'b1));
    script.push_back(make_req(CMD_SCROLL, 6'd0, 3'd0, 8'h00, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_SCROLL, 6'd0, 3'd0, 8'h00, FLAG_DISPLAY, 1'b0, 1'b1));
    script.push_back(make_req(CMD_GLYPH, 6'd5, 3'd1, 8'h07, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_GLYPH, 6'd63, 3'd7, 8'hFF, FLAG_DISPLAY, 1'b0, 1'b0));
    script.push_back(make_req(CMD_RESERVED_LO, 6'd63, 3'd7, 8'hFF, FLAG_RESERVED, 1'b1, 1'b1));
    script.push_back(make_req(CMD_RESERVED_HI, 6'd0, 3'd0, 8'h00, FLAG_DISPLAY, 1'b0, 1'b0));
    foreach (script[i]) begin
      offer(script[i], made_traffic);
    end
  endtask

  // One random phase at a fixed geometry. Only requests that make bus traffic
  // count toward the quota. Optionally a long receiver hold-off is asked for
  // while the sender keeps offering, or the sender pauses to drain mid-phase.
  task automatic run_phase(input logic [5:0] cols, input logic [2:0] rws, input int quota,
                           input bit with_hold, input bit with_pause);
    int   produced;
    bit   hold_given;
    bit   pause_given;
    bit   made_traffic;
    req_t r;
    produced    = 0;
    hold_given  = 1'b0;
    pause_given = 1'b0;
    settle();
    write_geometry(cols, rws);
    while (produced < quota) begin
      if (with_hold && !hold_given && (produced >= quota / 3)) begin
        hold_given = 1'b1;
        holds_asked++;
        straight_run = 40;
      end
      if (with_pause && !pause_given && (produced >= quota / 2)) begin
        pause_given = 1'b1;
        settle();
      end
      r = random_request(cols, rws);
      offer(r, made_traffic);
      if (made_traffic) begin
        produced++;
      end
    end
  endtask

  initial begin
    sb = new();
    // Reset is held at the start and never asserted again.
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    run_directed();

    // Geometries include both extremes: the widest four-line panel and a
    // single cell, where a character that follows a character always has to wrap.
    run_phase(6'd40, 3'd4, 80, 1'b1, 1'b0);
    run_phase(6'd1, 3'd1, 60, 1'b0, 1'b0);
    run_phase(6'd20, 3'd4, 80, 1'b0, 1'b1);
    run_phase(6'd8, 3'd3, 70, 1'b0, 1'b0);
    run_phase(6'($urandom_range(1, 40)), 3'($urandom_range(1, 4)), 80, 1'b1, 1'b0);
    run_phase(COLUMNS_RESET, ROWS_RESET, 70, 1'b0, 1'b1);

    settle();
    sb.flush_owed();

    $display("tb: %0d requests (%0d with no bus traffic), %0d nibbles checked, %0d mismatches",
             total_requests, quiet_requests, sb.checked, sb.mismatches);
    $display("tb: %0d panel geometries from 1x1 up to 40x4, long output hold-offs and drains",
             geometries);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/lcdte_pkg.sv
rtl/lcdte_fifo.sv
rtl/lcdte_front.sv
rtl/lcdte_back.sv
rtl/char_lcd_text_command_engine_top.sv
rtl/lcdte_checker.sv
verif/char_lcd_text_command_engine_top_tb.sv
